### hw/rtl/led_matrix_framebuffer_bar_driver_unit_assert.svh
// ----------------------------------------------------------------------------
// LED matrix driver assertion macros
// Shared property forms for the checks at the end of the driver unit module.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_FRAMEBUFFER_BAR_DRIVER_UNIT_ASSERT_SVH
`define LED_MATRIX_FRAMEBUFFER_BAR_DRIVER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LMFB_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LMFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lmfb_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix driver package
// Request codes, controller register addresses, divider sizing and the
// frame and bar pattern helpers.
// ----------------------------------------------------------------------------
package lmfb_pkg;

    localparam int ROWS    = 8;
    localparam int ROW_W   = $clog2(ROWS);

    localparam logic [3:0] DIGIT_BASE = 4'd1;

    // request codes
    localparam logic [3:0] REQ_INIT      = 4'd0;
    localparam logic [3:0] REQ_INTENSITY = 4'd1;
    localparam logic [3:0] REQ_CLEAR     = 4'd2;
    localparam logic [3:0] REQ_PIXEL     = 4'd3;
    localparam logic [3:0] REQ_ROW       = 4'd4;
    localparam logic [3:0] REQ_COLUMN    = 4'd5;
    localparam logic [3:0] REQ_BAR_ROW   = 4'd6;
    localparam logic [3:0] REQ_BAR_COL   = 4'd7;
    localparam logic [3:0] REQ_SHOW      = 4'd8;

    // controller register addresses
    localparam logic [3:0] REG_DECODE    = 4'h9;
    localparam logic [3:0] REG_INTENSITY = 4'hA;
    localparam logic [3:0] REG_SCAN      = 4'hB;
    localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
    localparam logic [3:0] REG_TEST      = 4'hF;

    localparam logic [3:0] LEVEL_MAX     = 4'hF;

    // frame sequence: five setup frames, then one frame per row
    localparam int         STEP_W         = 4;
    localparam logic [3:0] STEP_INTENSITY = 4'd3;
    localparam logic [3:0] STEP_ROWS      = 4'd5;
    localparam logic [3:0] STEP_LAST      = 4'd12;

    // shared divider: dividend below 2^21, quotient saturates at 31
    localparam int DIV_W  = 22;
    localparam int QUOT_W = 5;
    localparam int CNT_W  = $clog2(QUOT_W);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // setup frame {addr, data} for steps before the row frames
    function automatic logic [11:0] setup_frame(input logic [3:0] step,
                                                input logic [3:0] lvl);
        logic [11:0] f;
        case (step)
            4'd0:    f = {REG_TEST, 8'h00};
            4'd1:    f = {REG_DECODE, 8'h00};
            4'd2:    f = {REG_SCAN, 8'h07};
            4'd3:    f = {REG_INTENSITY, 4'h0, lvl};
            default: f = {REG_SHUTDOWN, 8'h01};
        endcase
        return f;
    endfunction

    // n lowest bits set, n in 0..8
    function automatic logic [7:0] plain_bar(input logic [3:0] n);
        logic [8:0] ones;
        ones = (9'd1 << n) - 9'd1;
        return ones[7:0];
    endfunction

    // centered bar, n in 0..4: positive grows down from bit 3, negative up from 4
    function automatic logic [7:0] center_bar(input logic [2:0] n, input logic pos);
        logic [4:0] ones;
        logic [7:0] p;
        ones = (5'd1 << n) - 5'd1;
        if (pos)
        begin
            p = {4'h0, ~ones[3:0] & 4'hF};
            p = (n == 3'd0) ? 8'h00 : {4'h0, 4'hF & ~((4'h1 << (3'd4 - n)) - 4'h1)};
        end
        else
        begin
            p = {ones[3:0], 4'h0};
        end
        return p;
    endfunction

endpackage

### hw/rtl/lmfb_div.sv
// ----------------------------------------------------------------------------
// LED matrix driver shared divider
// Restoring compare-subtract unit, one quotient bit per cycle, quotient
// saturating at all ones.
// ----------------------------------------------------------------------------
module lmfb_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [lmfb_pkg::DIV_W-1:0]       dividend,
    input  logic [lmfb_pkg::DIV_W-1:0]       divisor,
    output lmfb_pkg::div_stat_t              stat,
    output logic [lmfb_pkg::QUOT_W-1:0]      quot
);

    logic [lmfb_pkg::DIV_W-1:0]  rem_reg;
    logic [lmfb_pkg::DIV_W-1:0]  dvs_reg;
    logic [lmfb_pkg::QUOT_W-1:0] q_reg;
    logic [lmfb_pkg::CNT_W-1:0]  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic                        ge;

    assign ge = (rem_reg >= dvs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == lmfb_pkg::CNT_W'(lmfb_pkg::QUOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dvs_reg <= divisor << (lmfb_pkg::QUOT_W - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            // subtract the shifted divisor where it fits, then step it down
            if (ge)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            q_reg   <= {q_reg[lmfb_pkg::QUOT_W-2:0], ge};
            dvs_reg <= dvs_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

### hw/rtl/led_matrix_framebuffer_bar_driver_unit.sv
// Silent requests finish at accept; intensity emits its one frame, show the row
//   frames and init the set-up and row frames, one frame per cycle while out_ready is high.
// Bar requests go through the accept, the set-up states S_PREP and S_LOAD, five divider
//   steps and one write.
// Throughput: one request at a time; in_ready is high only while idle.
// Reset clears the frame buffer to all zero and leaves the output empty.
// ----------------------------------------------------------------------------
// LED matrix frame buffer and bar driver
// Holds an 8x8 frame buffer, applies requests and emits controller frames.
// ----------------------------------------------------------------------------
module led_matrix_framebuffer_bar_driver_unit #(
    parameter logic [3:0] DIGIT_BASE = lmfb_pkg::DIGIT_BASE
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         req_type,
    input  logic [3:0]         index,
    input  logic [3:0]         column,
    input  logic               on,
    input  logic [7:0]         bits,
    input  logic [7:0]         level,
    input  logic signed [15:0] value,
    input  logic signed [15:0] low_bound,
    input  logic signed [15:0] high_bound,
    input  logic               centered,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         reg_addr,
    output logic [7:0]         reg_data,
    output logic               last
);

    `include "led_matrix_framebuffer_bar_driver_unit_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_LOAD,
        S_WAIT,
        S_EMIT
    } state_t;

    state_t                              state_reg;
    logic [lmfb_pkg::STEP_W-1:0]         step_reg;
    logic                                out_valid_reg;
    logic [3:0]                          reg_addr_reg;
    logic [7:0]                          reg_data_reg;
    logic                                last_reg;

    logic [7:0]                          frame_reg [lmfb_pkg::ROWS];

    logic [3:0]                          req_reg;
    logic [3:0]                          index_reg;
    logic [3:0]                          column_reg;
    logic                                centered_reg;
    logic [3:0]                          level_reg;
    logic signed [16:0]                  num_reg;
    logic signed [16:0]                  span_reg;

    logic [16:0]                         num_abs_reg;
    logic [16:0]                         span_abs_reg;
    logic [18:0]                         tn_abs_reg;
    logic                                plain_neg_reg;
    logic                                center_pos_reg;
    logic                                tn_zero_reg;
    logic                                span_zero_reg;

    logic                                in_fire;
    logic                                emit_slot;
    logic                                frame_last;
    logic [lmfb_pkg::ROW_W-1:0]          row_sel;
    logic [11:0]                         setup_f;
    logic [3:0]                          frame_addr;
    logic [7:0]                          frame_data;

    logic signed [16:0]                  num_c;
    logic signed [16:0]                  span_c;
    logic signed [18:0]                  tn_c;
    logic [16:0]                         mag_c;
    logic [lmfb_pkg::DIV_W-1:0]          dividend_c;
    logic [lmfb_pkg::DIV_W-1:0]          divisor_c;

    lmfb_pkg::div_stat_t                 div_stat;
    logic [lmfb_pkg::QUOT_W-1:0]         quot;
    logic [3:0]                          n_plain;
    logic [2:0]                          n_center;
    logic [7:0]                          bar_pat;

    logic                                show_fire;
    logic                                show_first;
    logic                                step_ok;

    function automatic logic [lmfb_pkg::DIV_W-1:0] DIV_W_EXT(input logic [16:0] x);
        return lmfb_pkg::DIV_W'(x);
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign emit_slot = !out_valid_reg || out_ready;
    assign frame_last = (req_reg == lmfb_pkg::REQ_INTENSITY) ||
                        (step_reg == lmfb_pkg::STEP_LAST);

    // frame for the current step
    assign row_sel = lmfb_pkg::ROW_W'(step_reg - lmfb_pkg::STEP_ROWS);
    assign setup_f = lmfb_pkg::setup_frame(step_reg, level_reg);
    always_comb
    begin
        if (step_reg < lmfb_pkg::STEP_ROWS)
        begin
            frame_addr = setup_f[11:8];
            frame_data = setup_f[7:0];
        end
        else
        begin
            frame_addr = DIGIT_BASE + {1'b0, row_sel};
            frame_data = frame_reg[row_sel];
        end
    end

    // bar arithmetic operands
    assign num_c  = 17'(value) - 17'(low_bound);
    assign span_c = 17'(high_bound) - 17'(low_bound);
    assign tn_c   = {num_reg[16], num_reg, 1'b0} - {{2{span_reg[16]}}, span_reg};
    assign mag_c  = (tn_abs_reg > 19'(span_abs_reg)) ? span_abs_reg : tn_abs_reg[16:0];
    assign dividend_c = centered_reg ?
                        (DIV_W_EXT(mag_c) << 3) + DIV_W_EXT(span_abs_reg) :
                        (DIV_W_EXT(num_abs_reg) << 4) + DIV_W_EXT(span_abs_reg);
    assign divisor_c  = DIV_W_EXT(span_abs_reg) << 1;

    lmfb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_LOAD),
        .dividend (dividend_c),
        .divisor  (divisor_c),
        .stat     (div_stat),
        .quot     (quot)
    );

    // clamp the rounded quotient and form the pattern
    always_comb
    begin
        n_plain  = (quot[4] || (quot[3:0] > 4'd8)) ? 4'd8 : quot[3:0];
        n_center = (quot > 5'd4) ? 3'd4 : quot[2:0];
        if (span_zero_reg)
        begin
            bar_pat = 8'h00;
        end
        else if (centered_reg)
        begin
            bar_pat = tn_zero_reg ? 8'h00 : lmfb_pkg::center_bar(n_center, center_pos_reg);
        end
        else
        begin
            bar_pat = plain_neg_reg ? 8'h00 : lmfb_pkg::plain_bar(n_plain);
        end
    end

    // request fields and bar set-up
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg      <= req_type;
            index_reg    <= index;
            column_reg   <= column;
            centered_reg <= centered;
            level_reg    <= (level > 8'(lmfb_pkg::LEVEL_MAX)) ? lmfb_pkg::LEVEL_MAX : level[3:0];
            num_reg      <= num_c;
            span_reg     <= span_c;
        end
        if (state_reg == S_PREP)
        begin
            num_abs_reg    <= num_reg[16] ? 17'(-num_reg) : 17'(num_reg);
            span_abs_reg   <= span_reg[16] ? 17'(-span_reg) : 17'(span_reg);
            tn_abs_reg     <= tn_c[18] ? 19'(-tn_c) : 19'(tn_c);
            plain_neg_reg  <= (num_reg[16] != span_reg[16]);
            center_pos_reg <= (tn_c[18] == span_reg[16]);
            tn_zero_reg    <= (tn_c == '0);
            span_zero_reg  <= (span_reg == '0);
        end
    end

    // frame buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < lmfb_pkg::ROWS; r++)
            begin
                frame_reg[r] <= 8'h00;
            end
        end
        else if (in_fire)
        begin
            case (req_type)
                lmfb_pkg::REQ_INIT,
                lmfb_pkg::REQ_CLEAR:
                begin
                    for (int r = 0; r < lmfb_pkg::ROWS; r++)
                    begin
                        frame_reg[r] <= 8'h00;
                    end
                end
                lmfb_pkg::REQ_PIXEL:
                begin
                    if (!index[3] && !column[3])
                    begin
                        frame_reg[index[2:0]][column[2:0]] <= on;
                    end
                end
                lmfb_pkg::REQ_ROW:
                begin
                    if (!index[3])
                    begin
                        frame_reg[index[2:0]] <= bits;
                    end
                end
                lmfb_pkg::REQ_COLUMN:
                begin
                    if (!column[3])
                    begin
                        for (int r = 0; r < lmfb_pkg::ROWS; r++)
                        begin
                            frame_reg[r][column[2:0]] <= bits[r];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if ((state_reg == S_WAIT) && div_stat.done)
        begin
            // drop bar writes aimed outside the matrix
            if ((req_reg == lmfb_pkg::REQ_BAR_ROW) && !index_reg[3])
            begin
                frame_reg[index_reg[2:0]] <= bar_pat;
            end
            else if ((req_reg == lmfb_pkg::REQ_BAR_COL) && !column_reg[3])
            begin
                for (int r = 0; r < lmfb_pkg::ROWS; r++)
                begin
                    frame_reg[r][column_reg[2:0]] <= bar_pat[r];
                end
            end
        end
    end

    // sequencer and output frame register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            reg_addr_reg  <= '0;
            reg_data_reg  <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            // while emitting, the emit arm owns the output register
            if (out_ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (req_type)
                            lmfb_pkg::REQ_INIT:
                            begin
                                step_reg  <= '0;
                                state_reg <= S_EMIT;
                            end
                            lmfb_pkg::REQ_INTENSITY:
                            begin
                                step_reg  <= lmfb_pkg::STEP_INTENSITY;
                                state_reg <= S_EMIT;
                            end
                            lmfb_pkg::REQ_SHOW:
                            begin
                                step_reg  <= lmfb_pkg::STEP_ROWS;
                                state_reg <= S_EMIT;
                            end
                            lmfb_pkg::REQ_BAR_ROW,
                            lmfb_pkg::REQ_BAR_COL:
                            begin
                                state_reg <= S_PREP;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_PREP:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (emit_slot)
                    begin
                        out_valid_reg <= 1'b1;
                        reg_addr_reg  <= frame_addr;
                        reg_data_reg  <= frame_data;
                        last_reg      <= frame_last;
                        if (frame_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign reg_addr  = reg_addr_reg;
    assign reg_data  = reg_data_reg;
    assign last      = last_reg;

    assign show_fire  = in_fire && (req_type == lmfb_pkg::REQ_SHOW);
    assign show_first = (state_reg == S_EMIT) && (step_reg == lmfb_pkg::STEP_ROWS);
    assign step_ok    = (step_reg <= lmfb_pkg::STEP_LAST);

    `LMFB_ASSERT_HOLDS(a_done_in_wait, div_stat.done, state_reg == S_WAIT, "done outside wait")
    `LMFB_ASSERT_HOLDS(a_idle_div_quiet, state_reg == S_IDLE, !div_stat.busy, "busy while idle")
    `LMFB_ASSERT_HOLDS(a_step_bound, state_reg == S_EMIT, step_ok, "frame step past end")
    `LMFB_ASSERT_NEXT(a_show_start, show_fire, show_first, "show did not start at first row")

endmodule
